[rtl/asdf_pkg.sv]
package asdf_pkg;

   localparam int INDEX_W  = 12;
   localparam int FIELD_W  = 24;
   localparam int DIST_W   = 26;
   localparam int CSR_W    = 26;
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DISTANCE = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_COL_DOWN,
      PH_COL_UP,
      PH_ROW_FWD,
      PH_ROW_BACK
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VISIT_RD,
      ST_VISIT_OB,
      ST_VISIT_DIFF,
      ST_SQUARE,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_UPDATE,
      ST_ADVANCE,
      ST_EXEC,
      ST_CLEAR,
      ST_READ
   } ctl_state_type;

   typedef struct packed {
      logic                     command;
      logic [INDEX_W-1:0]       cell_index;
      logic                     blocked;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
      logic                     last_cell;
   } req_type;

   typedef struct packed {
      logic latch;
      logic rd_cell;
      logic ob;
      logic diff;
      logic sq_run;
      logic sqrt_init;
      logic sqrt_run;
      logic upd;
      logic adv;
      logic load;
      logic clear;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scanning;
      logic is_read;
      logic start;
      logic seen_next;
      logic sq_done;
      logic sqrt_done;
      logic clear_done;
      logic rsp_pending;
   } dp_status_type;

endpackage

[rtl/asdf_req_if.sv]
interface asdf_req_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        command;
   logic [asdf_pkg::INDEX_W-1:0]                cell_index;
   logic                                        blocked;
   logic signed [asdf_pkg::FIELD_W-1:0]         pos_x;
   logic signed [asdf_pkg::FIELD_W-1:0]         pos_y;
   logic signed [asdf_pkg::FIELD_W-1:0]         pos_z;
   logic                                        last_cell;

   modport source (output valid, command, cell_index, blocked, pos_x, pos_y, pos_z, last_cell,
                   input ready);
   modport sink (input valid, command, cell_index, blocked, pos_x, pos_y, pos_z, last_cell,
                 output ready);
endinterface

[rtl/asdf_rsp_if.sv]
interface asdf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [asdf_pkg::DIST_W-1:0]   distance;
   logic                          busy_res;
   logic                          index_error;

   modport source (output valid, distance, busy_res, index_error, input ready);
   modport sink (input valid, distance, busy_res, index_error, output ready);
endinterface

[rtl/axis_scan_distance_field.sv]
// channel   dir  handshake       payload
// req_chan  in   valid / ready   command, cell_index, blocked, pos_x/y/z, last_cell
// rsp_chan  out  valid / ready   distance, busy_res, index_error
// csr       in   csr_we          csr_index, csr_wdata
//
// While the scans run, each request first walks one cell: without a known
// obstacle the walk only advances, else it also evaluates a distance (three
// squares on one shared multiplier, 32-step square root). The load that starts
// the scans is followed by a clear pass over all MAX_COLUMNS*MAX_ROWS entries
// of the distance memory; no request is taken then.
// Synchronous active-high reset; a pending response stalls new requests.
module axis_scan_distance_field #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   asdf_req_if.sink                           req_chan,
   asdf_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [asdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [asdf_pkg::CSR_W-1:0]         csr_wdata
);

   asdf_pkg::dp_cmd_type    cmd;
   asdf_pkg::dp_status_type status;
   asdf_pkg::req_type       req;

   assign req.command    = req_chan.command;
   assign req.cell_index = req_chan.cell_index;
   assign req.blocked    = req_chan.blocked;
   assign req.pos_x      = req_chan.pos_x;
   assign req.pos_y      = req_chan.pos_y;
   assign req.pos_z      = req_chan.pos_z;
   assign req.last_cell  = req_chan.last_cell;

   asdf_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   asdf_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req             (req),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_distance    (rsp_chan.distance),
      .rsp_busy        (rsp_chan.busy_res),
      .rsp_index_error (rsp_chan.index_error)
   );

endmodule

[rtl/asdf_datapath.sv]
module asdf_datapath #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  asdf_pkg::dp_cmd_type                  cmd,
   output asdf_pkg::dp_status_type               status,
   input  asdf_pkg::req_type                     req,
   input  logic                                  csr_we,
   input  logic [asdf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [asdf_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [asdf_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                  rsp_busy,
   output logic                                  rsp_index_error
);

   localparam int CELLS   = MAX_COLUMNS * MAX_ROWS;
   localparam int CIW     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int PW      = $clog2(MAX_DIM + 1);
   localparam int AW      = 2 * PW + 1;
   localparam int CB      = COORD_BITS;
   localparam int ENTRY_W = 3 * CB + 1;
   localparam int DW      = asdf_pkg::DIST_W;

   function automatic logic [PW-1:0] clamp_count(logic [asdf_pkg::COUNT_W-1:0] v, int lim);
      logic [PW-1:0] r;
      if (v == '0) begin
         r = PW'(1);
      end else if (int'(v) > lim) begin
         r = PW'(lim);
      end else begin
         r = PW'(v);
      end
      return r;
   endfunction

   // raw field bits; the sign is taken from bit CB-1 of the stored coordinate
   function automatic logic [CB-1:0] to_coord(logic signed [asdf_pkg::FIELD_W-1:0] v);
      logic [31:0] w;
      w = 32'($unsigned(v));
      return w[CB-1:0];
   endfunction

   function automatic logic [31:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
      logic signed [33:0] sa;
      logic signed [33:0] sb;
      logic signed [33:0] d;
      logic [33:0]        m;
      sa = 34'($signed(a));
      sb = 34'($signed(b));
      d  = sa - sb;
      m  = d[33] ? 34'(-d) : 34'(d);
      return (m[33:32] != 2'b00) ? 32'hFFFF_FFFF : m[31:0];
   endfunction

   // configuration
   logic [asdf_pkg::COUNT_W-1:0] col_cfg_ff, row_cfg_ff;
   logic [DW-1:0]                init_cfg_ff;

   // request and scan state
   asdf_pkg::req_type   req_ff;
   logic                bad_ff;
   asdf_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]       pos_ff, pos_in, line_ff, line_in;
   logic [PW-1:0]       cols_ff, rows_ff;
   logic [DW-1:0]       init_ff;
   logic                seen_ff, seen_in;
   logic [CIW-1:0]      last_ff;
   logic [CIW-1:0]      clr_ff;

   // distance evaluation
   logic [3*CB-1:0]     cur_pos_ff;
   logic [DW-1:0]       old_dist_ff;
   logic [31:0]         mag_ff [3];
   logic [63:0]         prod_ff, acc_ff, rad_ff;
   logic [35:0]         rem_ff;
   logic [31:0]         root_ff;
   logic [4:0]          step_ff;

   // memories
   logic [ENTRY_W-1:0]  cell_mem [CELLS];
   logic [DW-1:0]       dist_mem [CELLS];
   logic [ENTRY_W-1:0]  cell_rd_ff;
   logic [DW-1:0]       dist_rd_ff;

   logic                rsp_valid_ff;
   logic [DW-1:0]       rsp_distance_ff;
   logic                rsp_busy_ff, rsp_index_error_ff;

   logic [PW-1:0]       ec, er;
   logic                bad_now;
   logic [CIW-1:0]      req_addr;
   logic [PW-1:0]       va_major, va_minor;
   logic [AW-1:0]       va_wide;
   logic [CIW-1:0]      visit_addr;
   logic                blk_now;
   logic [CIW-1:0]      cell_raddr, dist_raddr;
   logic [31:0]         sq_sel;
   logic [64:0]         acc_sum;
   logic [35:0]         rem_sh, trial;
   logic [DW-1:0]       dist_new;
   logic                col_phase;

   assign ec       = clamp_count(col_cfg_ff, MAX_COLUMNS);
   assign er       = clamp_count(row_cfg_ff, MAX_ROWS);
   assign bad_now  = 32'(req.cell_index) >= (32'(ec) * 32'(er));
   assign req_addr = CIW'(req_ff.cell_index);

   assign col_phase = (phase_ff == asdf_pkg::PH_COL_DOWN) || (phase_ff == asdf_pkg::PH_COL_UP);
   assign va_major  = col_phase ? line_ff : pos_ff;
   assign va_minor  = col_phase ? pos_ff : line_ff;
   assign va_wide   = AW'(va_major) * AW'(rows_ff) + AW'(va_minor);
   assign visit_addr = CIW'(va_wide);

   assign blk_now    = cell_rd_ff[ENTRY_W-1];
   assign cell_raddr = (cmd.ob && !blk_now) ? last_ff : visit_addr;
   assign dist_raddr = cmd.rd_cell ? visit_addr : req_addr;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    sq_sel = mag_ff[0];
         2'd1:    sq_sel = mag_ff[1];
         default: sq_sel = mag_ff[2];
      endcase
   end

   assign acc_sum = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign dist_new = (root_ff > 32'(asdf_pkg::DIST_MAX)) ? asdf_pkg::DIST_MAX : DW'(root_ff);

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load && !bad_ff) begin
         cell_mem[req_addr] <= {req_ff.blocked, to_coord(req_ff.pos_x),
                                to_coord(req_ff.pos_y), to_coord(req_ff.pos_z)};
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         dist_mem[clr_ff] <= init_ff;
      end else if (cmd.upd && (dist_new < old_dist_ff)) begin
         dist_mem[visit_addr] <= dist_new;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cfg_ff  <= asdf_pkg::COUNT_W'(64);
         row_cfg_ff  <= asdf_pkg::COUNT_W'(64);
         init_cfg_ff <= asdf_pkg::DIST_MAX;
      end else if (csr_we) begin
         unique case (csr_index)
            asdf_pkg::CSR_COLUMN_COUNT:     col_cfg_ff  <= csr_wdata[asdf_pkg::COUNT_W-1:0];
            asdf_pkg::CSR_ROW_COUNT:        row_cfg_ff  <= csr_wdata[asdf_pkg::COUNT_W-1:0];
            asdf_pkg::CSR_INITIAL_DISTANCE: init_cfg_ff <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // request latch and evaluation datapath
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req;
         bad_ff <= bad_now;
      end
      if (cmd.ob) begin
         cur_pos_ff  <= cell_rd_ff[3*CB-1:0];
         old_dist_ff <= dist_rd_ff;
      end
      if (cmd.diff) begin
         mag_ff[0] <= abs_diff(cur_pos_ff[3*CB-1:2*CB], cell_rd_ff[3*CB-1:2*CB]);
         mag_ff[1] <= abs_diff(cur_pos_ff[2*CB-1:CB], cell_rd_ff[2*CB-1:CB]);
         mag_ff[2] <= abs_diff(cur_pos_ff[CB-1:0], cell_rd_ff[CB-1:0]);
         acc_ff    <= '0;
      end
      if (cmd.sq_run) begin
         prod_ff <= sq_sel * sq_sel;
         // the product of the previous step is accumulated here
         if (step_ff != 5'd0) begin
            acc_ff <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
         end
      end
      if (cmd.sqrt_init) begin
         rad_ff  <= acc_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_run) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.load && req_ff.last_cell && !bad_ff) begin
         cols_ff <= ec;
         rows_ff <= er;
         init_ff <= init_cfg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.diff || cmd.sqrt_init) begin
            step_ff <= '0;
         end else if (cmd.sq_run || cmd.sqrt_run) begin
            step_ff <= step_ff + 5'd1;
         end
         if (cmd.load) begin
            clr_ff <= '0;
         end else if (cmd.clear) begin
            clr_ff <= clr_ff + CIW'(1);
         end
      end
   end

   // scan walk
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      seen_in  = seen_ff;
      if (cmd.ob && blk_now) begin
         seen_in = 1'b1;
      end
      if (cmd.adv) begin
         unique case (phase_ff)
            asdf_pkg::PH_COL_DOWN: begin
               if (pos_ff + PW'(1) >= rows_ff) begin
                  phase_in = asdf_pkg::PH_COL_UP;
                  pos_in   = rows_ff - PW'(1);
                  seen_in  = 1'b0;
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
            end
            asdf_pkg::PH_COL_UP: begin
               if (pos_ff == '0) begin
                  seen_in = 1'b0;
                  if (line_ff + PW'(1) >= cols_ff) begin
                     phase_in = asdf_pkg::PH_ROW_FWD;
                     line_in  = '0;
                  end else begin
                     phase_in = asdf_pkg::PH_COL_DOWN;
                     line_in  = line_ff + PW'(1);
                  end
               end else begin
                  pos_in = pos_ff - PW'(1);
               end
            end
            asdf_pkg::PH_ROW_FWD: begin
               if (pos_ff + PW'(1) >= cols_ff) begin
                  phase_in = asdf_pkg::PH_ROW_BACK;
                  pos_in   = cols_ff - PW'(1);
                  seen_in  = 1'b0;
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
            end
            asdf_pkg::PH_ROW_BACK: begin
               if (pos_ff == '0) begin
                  seen_in = 1'b0;
                  if (line_ff + PW'(1) >= rows_ff) begin
                     phase_in = asdf_pkg::PH_IDLE;
                     line_in  = '0;
                  end else begin
                     phase_in = asdf_pkg::PH_ROW_FWD;
                     line_in  = line_ff + PW'(1);
                  end
               end else begin
                  pos_in = pos_ff - PW'(1);
               end
            end
            default: phase_in = asdf_pkg::PH_IDLE;
         endcase
      end
      if (cmd.load && req_ff.last_cell && !bad_ff) begin
         phase_in = asdf_pkg::PH_COL_DOWN;
         pos_in   = '0;
         line_in  = '0;
         seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asdf_pkg::PH_IDLE;
         pos_ff   <= '0;
         line_ff  <= '0;
         seen_ff  <= 1'b0;
         last_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         seen_ff  <= seen_in;
         if (cmd.ob && blk_now) begin
            last_ff <= visit_addr;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_busy_ff        <= phase_ff != asdf_pkg::PH_IDLE;
         rsp_index_error_ff <= bad_ff;
         rsp_distance_ff    <= ((phase_ff != asdf_pkg::PH_IDLE) || bad_ff) ? '0 : dist_rd_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_busy        = rsp_busy_ff;
   assign rsp_index_error = rsp_index_error_ff;

   assign status.scanning    = phase_ff != asdf_pkg::PH_IDLE;
   assign status.is_read     = req_ff.command == asdf_pkg::CMD_READ;
   assign status.start       = req_ff.last_cell && !bad_ff;
   assign status.seen_next   = seen_ff || blk_now;
   assign status.sq_done     = step_ff == 5'd3;
   assign status.sqrt_done   = step_ff == 5'd31;
   assign status.clear_done  = clr_ff == CIW'(CELLS - 1);
   assign status.rsp_pending = rsp_valid_ff;

endmodule

[rtl/asdf_controller.sv]
module asdf_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output asdf_pkg::dp_cmd_type     cmd,
   input  asdf_pkg::dp_status_type  status
);

   asdf_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         asdf_pkg::ST_IDLE: begin
            req_ready = !status.rsp_pending;
            if (req_valid && !status.rsp_pending) begin
               cmd.latch = 1'b1;
               state_in  = status.scanning ? asdf_pkg::ST_VISIT_RD : asdf_pkg::ST_EXEC;
            end
         end
         asdf_pkg::ST_VISIT_RD: begin
            cmd.rd_cell = 1'b1;
            state_in    = asdf_pkg::ST_VISIT_OB;
         end
         asdf_pkg::ST_VISIT_OB: begin
            cmd.ob   = 1'b1;
            state_in = status.seen_next ? asdf_pkg::ST_VISIT_DIFF : asdf_pkg::ST_ADVANCE;
         end
         asdf_pkg::ST_VISIT_DIFF: begin
            cmd.diff = 1'b1;
            state_in = asdf_pkg::ST_SQUARE;
         end
         asdf_pkg::ST_SQUARE: begin
            cmd.sq_run = 1'b1;
            if (status.sq_done) begin
               state_in = asdf_pkg::ST_SQRT_INIT;
            end
         end
         asdf_pkg::ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            state_in      = asdf_pkg::ST_SQRT;
         end
         asdf_pkg::ST_SQRT: begin
            cmd.sqrt_run = 1'b1;
            if (status.sqrt_done) begin
               state_in = asdf_pkg::ST_UPDATE;
            end
         end
         asdf_pkg::ST_UPDATE: begin
            cmd.upd  = 1'b1;
            state_in = asdf_pkg::ST_ADVANCE;
         end
         asdf_pkg::ST_ADVANCE: begin
            cmd.adv  = 1'b1;
            state_in = asdf_pkg::ST_EXEC;
         end
         asdf_pkg::ST_EXEC: begin
            if (status.is_read) begin
               state_in = asdf_pkg::ST_READ;
            end else begin
               cmd.load = 1'b1;
               state_in = status.start ? asdf_pkg::ST_CLEAR : asdf_pkg::ST_IDLE;
            end
         end
         asdf_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = asdf_pkg::ST_IDLE;
            end
         end
         asdf_pkg::ST_READ: begin
            cmd.rsp_load = 1'b1;
            state_in     = asdf_pkg::ST_IDLE;
         end
         default: state_in = asdf_pkg::ST_IDLE;
      endcase
   end

endmodule
